### hw/rtl/ibd_pkg.sv
`default_nettype none

package ibd_pkg;

   // Widths fixed by the item and register formats
   localparam int PIX_W     = 8;
   localparam int SUM_W     = 16;
   localparam int POS_W     = 10;
   localparam int CFG_W     = 11;
   localparam int CFG_IDX_W = 2;
   localparam int BSIZE_W   = 5;

   localparam int MAX_HEIGHT = 1024;
   localparam int PAD_SHIFT  = 7;   // pad pixel value 128 = 1 << 7

   // Register indexes of the configuration port
   localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
   localparam logic [CFG_IDX_W-1:0] REG_BSIZE  = 2'd1;
   localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd2;
   localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic update;
      logic div_start_row;
      logic div_step;
      logic row_take;
      logic val_start;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic close;
      logic avg;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

### hw/rtl/image_block_decimator_unit.sv
// A pixel that closes no tile passes through the load and update states only; a
// tile-closing pixel then runs the bit-serial divider over TW bits (TW = 18 at defaults),
// which first forms the tile row and, in mean mode only, then the mean, before emit.
// A new pixel is taken only in the idle state, once the last one is through; the result register
// lets the next pixel enter while a result waits. Reset is synchronous, active high;
// the line store holds no reset and each entry is written before it is read.
`default_nettype none

module image_block_decimator_unit #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_BLOCK = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [ibd_pkg::PIX_W-1:0]         req_pixel,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [ibd_pkg::PIX_W-1:0]              rsp_block_value,
   output logic [ibd_pkg::POS_W-1:0]              rsp_block_row,
   output logic [ibd_pkg::POS_W-1:0]              rsp_block_col,
   output logic                                   rsp_last_block,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ibd_pkg::CFG_IDX_W-1:0]     csr_index,
   input  wire logic [ibd_pkg::CFG_W-1:0]         csr_data
);

   ibd_pkg::cmd_type    cmd;
   ibd_pkg::status_type status;

   assign csr_ready = 1'b1;

   ibd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ibd_datapath #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_BLOCK (MAX_BLOCK)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_pixel       (req_pixel),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_block_value (rsp_block_value),
      .rsp_block_row   (rsp_block_row),
      .rsp_block_col   (rsp_block_col),
      .rsp_last_block  (rsp_last_block)
   );

endmodule

`default_nettype wire

### hw/rtl/ibd_ctrl.sv
`default_nettype none

module ibd_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire ibd_pkg::status_type status,
   output ibd_pkg::cmd_type        cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPD,
      S_RDIV,
      S_VDIV,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Sequence one item: read, update, and on a tile close row divide, value divide (mean mode), emit
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            cmd.update = 1'b1;
            if (status.close) begin
               cmd.div_start_row = 1'b1;
               state_in          = S_RDIV;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RDIV: begin
            if (!status.div_done) begin
               cmd.div_step = 1'b1;
            end else begin
               cmd.row_take = 1'b1;
               if (status.avg) begin
                  cmd.val_start = 1'b1;
                  state_in      = S_VDIV;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_VDIV: begin
            if (!status.div_done) begin
               cmd.div_step = 1'b1;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result loaded while output register busy");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !status.div_done)
      else $error("divider stepped past its last bit");

   a_load_update: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.update)
      else $error("accepted item not followed by line store update");

endmodule

`default_nettype wire

### hw/rtl/ibd_datapath.sv
`default_nettype none

module ibd_datapath #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_BLOCK = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire ibd_pkg::cmd_type                     cmd,
   output ibd_pkg::status_type                       status,
   input  wire logic [ibd_pkg::PIX_W-1:0]            req_pixel,
   input  wire logic                                 csr_valid,
   input  wire logic [ibd_pkg::CFG_IDX_W-1:0]        csr_index,
   input  wire logic [ibd_pkg::CFG_W-1:0]            csr_data,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_valid,
   output logic [ibd_pkg::PIX_W-1:0]                 rsp_block_value,
   output logic [ibd_pkg::POS_W-1:0]                 rsp_block_row,
   output logic [ibd_pkg::POS_W-1:0]                 rsp_block_col,
   output logic                                      rsp_last_block
);

   localparam int PW   = $clog2(MAX_WIDTH);
   localparam int WW   = (PW + 1 > ibd_pkg::CFG_W) ? PW + 1 : ibd_pkg::CFG_W;
   localparam int BIW  = $clog2(MAX_BLOCK);
   localparam int BSW  = ($clog2(MAX_BLOCK + 1) > ibd_pkg::BSIZE_W) ?
                         $clog2(MAX_BLOCK + 1) : ibd_pkg::BSIZE_W;
   localparam int AW   = 2 * BSW;
   localparam int TW   = ((AW + ibd_pkg::PAD_SHIFT > ibd_pkg::SUM_W) ?
                          AW + ibd_pkg::PAD_SHIFT : ibd_pkg::SUM_W) + 1;
   localparam int CNW  = $clog2(TW + 1);

   // Configuration registers
   logic                          mode_ff;
   logic [ibd_pkg::BSIZE_W-1:0]   bsize_ff;
   logic [ibd_pkg::CFG_W-1:0]     iwidth_ff;
   logic [ibd_pkg::CFG_W-1:0]     iheight_ff;

   // Position counters
   logic [PW-1:0]                 pix_idx_ff;
   logic [ibd_pkg::POS_W-1:0]     line_idx_ff;
   logic [BIW-1:0]                pit_ff;
   logic [BIW-1:0]                lit_ff;
   logic [PW-1:0]                 tcol_ff;

   // Snapshot of the item in work
   logic [ibd_pkg::PIX_W-1:0]     px_ff;
   logic [PW-1:0]                 col_ff;
   logic                          top_left_ff;
   logic                          avg_ff;
   logic                          close_ff;
   logic                          last_ff;
   logic [ibd_pkg::POS_W-1:0]     line_ff;
   logic [BSW-1:0]                bs_ff;
   logic [AW-1:0]                 area_ff;
   logic [AW-1:0]                 rc_ff;
   logic [ibd_pkg::SUM_W-1:0]     rdata_ff;
   logic [ibd_pkg::SUM_W-1:0]     sum_ff;
   logic [ibd_pkg::POS_W-1:0]     row_ff;

   // Divider
   logic [TW-1:0]                 num_ff;
   logic [AW-1:0]                 rem_ff;
   logic [AW-1:0]                 dvs_ff;
   logic [CNW-1:0]                cnt_ff;

   // Output register
   logic                          rsp_valid_ff;
   logic [ibd_pkg::PIX_W-1:0]     rsp_value_ff;
   logic [ibd_pkg::POS_W-1:0]     rsp_row_ff;
   logic [ibd_pkg::POS_W-1:0]     rsp_col_ff;
   logic                          rsp_last_ff;

   // Line store of per-column partial sums
   logic [ibd_pkg::SUM_W-1:0]     tile_sums [MAX_WIDTH];

   logic [WW-1:0]                 iw_ext, w_eff;
   logic [ibd_pkg::CFG_W-1:0]     h_eff;
   logic [BSW-1:0]                bs_ext, bs_eff;
   logic                          line_end, image_end, h_close, v_close, top_left;
   logic [BSW-1:0]                rows_raw, cols_raw, rows, cols;
   logic [ibd_pkg::SUM_W-1:0]     wdata;
   logic                          wr_en;
   logic [AW:0]                   rem_sh, rem_diff;
   logic                          rem_ge;
   logic [ibd_pkg::PIX_W-1:0]     value;

   // Clamp registers to their usable ranges
   always_comb begin
      iw_ext = WW'(iwidth_ff);
      if (iw_ext == '0) w_eff = WW'(1);
      else if (iw_ext > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
      else w_eff = iw_ext;

      if (iheight_ff == '0) h_eff = ibd_pkg::CFG_W'(1);
      else if (iheight_ff > ibd_pkg::CFG_W'(ibd_pkg::MAX_HEIGHT))
         h_eff = ibd_pkg::CFG_W'(ibd_pkg::MAX_HEIGHT);
      else h_eff = iheight_ff;

      bs_ext = BSW'(bsize_ff);
      if (bs_ext == '0) bs_eff = BSW'(1);
      else if (bs_ext > BSW'(MAX_BLOCK)) bs_eff = BSW'(MAX_BLOCK);
      else bs_eff = bs_ext;
   end

   // Tile position flags of the current pixel
   always_comb begin
      line_end  = WW'(pix_idx_ff) >= (w_eff - WW'(1));
      image_end = ibd_pkg::CFG_W'(line_idx_ff) >= (h_eff - ibd_pkg::CFG_W'(1));
      h_close   = (BSW'(pit_ff) >= (bs_eff - BSW'(1))) || line_end;
      v_close   = (BSW'(lit_ff) >= (bs_eff - BSW'(1))) || image_end;
      top_left  = (lit_ff == '0) && (pit_ff == '0);
      rows_raw  = BSW'(lit_ff) + BSW'(1);
      cols_raw  = BSW'(pit_ff) + BSW'(1);
      rows      = (rows_raw > bs_eff) ? bs_eff : rows_raw;
      cols      = (cols_raw > bs_eff) ? bs_eff : cols_raw;
   end

   // Accumulate into the line store
   always_comb begin
      wr_en = top_left_ff || avg_ff;
      wdata = top_left_ff ? ibd_pkg::SUM_W'(px_ff) : rdata_ff + ibd_pkg::SUM_W'(px_ff);
   end

   // One restoring divide step
   always_comb begin
      rem_sh   = {rem_ff, num_ff[TW-1]};
      rem_ge   = rem_sh >= {1'b0, dvs_ff};
      rem_diff = rem_sh - {1'b0, dvs_ff};
   end

   // Saturate the mean, or keep the top-left pixel
   always_comb begin
      if (avg_ff) begin
         value = (|num_ff[TW-1:ibd_pkg::PIX_W]) ? '1 : num_ff[ibd_pkg::PIX_W-1:0];
      end else begin
         value = sum_ff[ibd_pkg::PIX_W-1:0];
      end
   end

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         bsize_ff   <= ibd_pkg::BSIZE_W'(8);
         iwidth_ff  <= ibd_pkg::CFG_W'(1024);
         iheight_ff <= ibd_pkg::CFG_W'(1024);
      end else if (csr_valid) begin
         case (csr_index)
            ibd_pkg::REG_MODE:   mode_ff    <= csr_data[0];
            ibd_pkg::REG_BSIZE:  bsize_ff   <= csr_data[ibd_pkg::BSIZE_W-1:0];
            ibd_pkg::REG_WIDTH:  iwidth_ff  <= csr_data;
            ibd_pkg::REG_HEIGHT: iheight_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Advance the raster position on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         pix_idx_ff  <= '0;
         line_idx_ff <= '0;
         pit_ff      <= '0;
         lit_ff      <= '0;
         tcol_ff     <= '0;
      end else if (cmd.load) begin
         if (line_end) begin
            pix_idx_ff <= '0;
            pit_ff     <= '0;
            tcol_ff    <= '0;
            if (image_end) begin
               line_idx_ff <= '0;
               lit_ff      <= '0;
            end else begin
               line_idx_ff <= line_idx_ff + ibd_pkg::POS_W'(1);
               lit_ff      <= (BSW'(lit_ff) >= (bs_eff - BSW'(1))) ?
                              '0 : lit_ff + BIW'(1);
            end
         end else begin
            pix_idx_ff <= pix_idx_ff + PW'(1);
            if (BSW'(pit_ff) >= (bs_eff - BSW'(1))) begin
               pit_ff  <= '0;
               tcol_ff <= (tcol_ff == PW'(MAX_WIDTH - 1)) ? '0 : tcol_ff + PW'(1);
            end else begin
               pit_ff <= pit_ff + BIW'(1);
            end
         end
      end
   end

   // Capture the item and read its column entry
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff       <= req_pixel;
         col_ff      <= tcol_ff;
         top_left_ff <= top_left;
         avg_ff      <= mode_ff;
         close_ff    <= h_close && v_close;
         last_ff     <= line_end && image_end;
         line_ff     <= line_idx_ff;
         bs_ff       <= bs_eff;
         area_ff     <= AW'(bs_eff) * AW'(bs_eff);
         rc_ff       <= AW'(rows) * AW'(cols);
         rdata_ff    <= tile_sums[tcol_ff];
      end
      if (cmd.update) begin
         if (wr_en) tile_sums[col_ff] <= wdata;
         sum_ff <= wr_en ? wdata : rdata_ff;
      end
   end

   // Shared divider: tile row first, then the tile mean in mean mode
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.div_start_row || cmd.val_start) begin
         cnt_ff <= CNW'(TW);
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff - CNW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.row_take) row_ff <= ibd_pkg::POS_W'(num_ff);
      if (cmd.div_start_row) begin
         num_ff <= TW'(line_ff);
         rem_ff <= '0;
         dvs_ff <= AW'(bs_ff);
      end else if (cmd.val_start) begin
         num_ff <= TW'(sum_ff) + (TW'(area_ff - rc_ff) << ibd_pkg::PAD_SHIFT);
         rem_ff <= '0;
         dvs_ff <= area_ff;
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? rem_diff[AW-1:0] : rem_sh[AW-1:0];
         num_ff <= {num_ff[TW-2:0], rem_ge};
      end
   end

   // Output register: load on emit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_value_ff <= value;
         rsp_row_ff   <= row_ff;
         rsp_col_ff   <= ibd_pkg::POS_W'(col_ff);
         rsp_last_ff  <= last_ff;
      end
   end

   assign status.close    = close_ff;
   assign status.avg      = avg_ff;
   assign status.div_done = (cnt_ff == '0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_block_value = rsp_value_ff;
   assign rsp_block_row   = rsp_row_ff;
   assign rsp_block_col   = rsp_col_ff;
   assign rsp_last_block  = rsp_last_ff;

endmodule

`default_nettype wire
